### src/permission_mode_spec_parser_assert.svh
// ----------------------------------------------------------------------------
// permission mode spec parser assertion macros
// shared assertion forms for the parser, clocked on the rising edge and
// disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef PERMISSION_MODE_SPEC_PARSER_ASSERT_SVH
`define PERMISSION_MODE_SPEC_PARSER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PMSP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PMSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/pmsp_pkg.sv
// ----------------------------------------------------------------------------
// pmsp_pkg
// types, character codes and mode constants of the permission mode parser
// ----------------------------------------------------------------------------
package pmsp_pkg;

   // item kinds carried in tuser
   localparam logic [1:0] KIND_BEGIN = 2'd0;
   localparam logic [1:0] KIND_CHAR  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   // ascii codes of the mode string
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_O     = 8'h6f;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_EQUAL = 8'h3d;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_W     = 8'h77;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_COMMA = 8'h2c;

   // who masks and permission bits
   localparam logic [8:0]  WHO_USER   = 9'o700;
   localparam logic [8:0]  WHO_GROUP  = 9'o070;
   localparam logic [8:0]  WHO_OTHER  = 9'o007;
   localparam logic [8:0]  WHO_ALL    = 9'o777;
   localparam logic [11:0] PERM_READ  = 12'o0444;
   localparam logic [11:0] PERM_WRITE = 12'o0222;
   localparam logic [11:0] PERM_EXEC  = 12'o0111;
   localparam logic [11:0] PERM_STICKY = 12'o1000;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_OCTAL  = 3'd1,
      PH_CLAUSE = 3'd2,
      PH_WHO    = 3'd3,
      PH_PERM   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_ADD  = 2'd1,
      OP_SUB  = 2'd2,
      OP_SET  = 2'd3
   } op_type;

   typedef struct packed {
      phase_type   phase;
      logic [11:0] mode_accum;
      logic [8:0]  who_mask;
      op_type      pending_op;
      logic        invalid_flag;
      logic        overflow_flag;
   } pmsp_state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] current_mode;
      logic [7:0]  char_code;
   } pmsp_item_type;

   typedef struct packed {
      logic [11:0] result_mode;
      logic [1:0]  status;
   } pmsp_result_type;

   localparam pmsp_state_type STATE_RESET = '{
      phase:         PH_START,
      mode_accum:    12'd0,
      who_mask:      9'd0,
      pending_op:    OP_NONE,
      invalid_flag:  1'b0,
      overflow_flag: 1'b0
   };

endpackage

### src/pmsp_step.sv
// ----------------------------------------------------------------------------
// pmsp_step
// next parser state and end-of-string result for one item
// ----------------------------------------------------------------------------
module pmsp_step (
   input  pmsp_pkg::pmsp_state_type  state_cur,
   input  pmsp_pkg::pmsp_item_type   item,
   output pmsp_pkg::pmsp_state_type  state_nxt,
   output pmsp_pkg::pmsp_result_type result
);
   import pmsp_pkg::*;

   function automatic logic [8:0] who_bits(input logic [7:0] c);
      case (c)
         CH_U:    return WHO_USER;
         CH_G:    return WHO_GROUP;
         CH_O:    return WHO_OTHER;
         CH_A:    return WHO_ALL;
         default: return 9'd0;
      endcase
   endfunction

   function automatic op_type op_code(input logic [7:0] c);
      case (c)
         CH_PLUS:  return OP_ADD;
         CH_MINUS: return OP_SUB;
         CH_EQUAL: return OP_SET;
         default:  return OP_NONE;
      endcase
   endfunction

   // operator seen: latch who and op, = clears the who bits right away
   function automatic pmsp_state_type start_op(input pmsp_state_type st,
                                                input op_type op,
                                                input logic [8:0] who);
      pmsp_state_type s;
      s = st;
      s.who_mask = who;
      s.pending_op = op;
      if (op == OP_SET) begin
         s.mode_accum = st.mode_accum & ~{3'b000, who};
      end
      s.phase = PH_PERM;
      return s;
   endfunction

   // first character of a clause
   function automatic pmsp_state_type clause_char(input pmsp_state_type st,
                                                   input logic [7:0] c);
      pmsp_state_type s;
      logic [8:0]     w;
      op_type         op;
      s = st;
      w = who_bits(c);
      op = op_code(c);
      if (w != 9'd0) begin
         s.who_mask = w;
         s.phase = PH_WHO;
      end else if (op != OP_NONE) begin
         s = start_op(st, op, WHO_ALL);
      end else begin
         s.invalid_flag = 1'b1;
      end
      return s;
   endfunction

   function automatic pmsp_state_type apply_perm(input pmsp_state_type st,
                                                  input logic [7:0] c);
      pmsp_state_type s;
      logic [11:0]    bits;
      s = st;
      case (c)
         CH_R:    bits = PERM_READ & {3'b000, st.who_mask};
         CH_W:    bits = PERM_WRITE & {3'b000, st.who_mask};
         CH_X:    bits = PERM_EXEC & {3'b000, st.who_mask};
         CH_S:    bits = {|st.who_mask[8:6], |st.who_mask[5:3], 10'd0};
         CH_T:    bits = PERM_STICKY;
         default: bits = 12'd0;
      endcase
      if (st.pending_op == OP_SUB) begin
         s.mode_accum = st.mode_accum & ~bits;
      end else begin
         s.mode_accum = st.mode_accum | bits;
      end
      return s;
   endfunction

   logic [7:0] c;
   logic [8:0] w;
   op_type     op;
   logic       bad;

   assign c = item.char_code;
   assign w = who_bits(c);
   assign op = op_code(c);

   always_comb begin
      state_nxt = state_cur;
      case (item.kind)
         KIND_BEGIN: begin
            state_nxt = STATE_RESET;
            state_nxt.mode_accum = item.current_mode;
         end
         KIND_CHAR: begin
            if (!state_cur.invalid_flag) begin
               case (state_cur.phase)
                  PH_START: begin
                     if (c inside {[CH_ZERO:CH_SEVEN]}) begin
                        state_nxt.mode_accum = {9'd0, c[2:0]};
                        state_nxt.phase = PH_OCTAL;
                     end else begin
                        state_nxt = clause_char(state_cur, c);
                     end
                  end
                  PH_OCTAL: begin
                     if (c inside {[CH_ZERO:CH_SEVEN]}) begin
                        if (state_cur.mode_accum[11:9] != 3'd0) begin
                           state_nxt.overflow_flag = 1'b1;
                        end
                        state_nxt.mode_accum = {state_cur.mode_accum[8:0], c[2:0]};
                     end else begin
                        state_nxt.invalid_flag = 1'b1;
                     end
                  end
                  PH_CLAUSE: begin
                     state_nxt = clause_char(state_cur, c);
                  end
                  PH_WHO: begin
                     if (w != 9'd0) begin
                        state_nxt.who_mask = state_cur.who_mask | w;
                     end else if (op != OP_NONE) begin
                        state_nxt = start_op(state_cur, op,
                           (state_cur.who_mask == 9'd0) ? WHO_ALL : state_cur.who_mask);
                     end else begin
                        state_nxt.invalid_flag = 1'b1;
                     end
                  end
                  PH_PERM: begin
                     if (c inside {CH_R, CH_W, CH_X, CH_S, CH_T}) begin
                        state_nxt = apply_perm(state_cur, c);
                     end else if (c == CH_COMMA) begin
                        state_nxt.phase = PH_CLAUSE;
                     end else begin
                        state_nxt = clause_char(state_cur, c);
                     end
                  end
                  default: begin
                     state_nxt.invalid_flag = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            // end item and unused kind leave the state alone
         end
      endcase
   end

   // an unfinished who list counts as invalid
   assign bad = state_cur.invalid_flag || (state_cur.phase == PH_WHO);

   always_comb begin
      if (bad) begin
         result.result_mode = 12'd0;
         result.status = ST_INVALID;
      end else begin
         result.result_mode = state_cur.mode_accum;
         result.status = state_cur.overflow_flag ? ST_OVERFLOW : ST_OK;
      end
   end

endmodule

### src/permission_mode_spec_parser.sv
// ----------------------------------------------------------------------------
// permission_mode_spec_parser
// streams a file permission mode string in, one byte per transaction, and
// returns the resulting 12-bit mode and a status on an end transaction
// ----------------------------------------------------------------------------
// Usage: send a begin transaction (tuser kind 0) carrying the current mode,
// then one character transaction (kind 1) per byte of the mode string, then
// an end transaction (kind 2). Only the end transaction produces a result:
// the resulting mode plus a status of ok, invalid string (mode reads zero) or
// octal overflow (mode holds the low 12 bits). A string starting with an octal
// digit is read as a number; otherwise as symbolic clauses such as
// "u+x,go=r". An end leaves the parse state alone, so a second end repeats
// the answer. Throughput is one transaction per clock; a result appears on
// rsp once its end transaction has passed from the input register into the
// result register. The only stall is an end transaction held in the input
// register while the result register still holds an untaken result.
`include "permission_mode_spec_parser_assert.svh"

module permission_mode_spec_parser (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [11:0] current_mode, [19:12] char_code, [23:20] zero
   input  logic [1:0]  req_tuser,  // [1:0] kind
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [11:0] result_mode, [15:12] zero
   output logic [1:0]  rsp_tuser   // [1:0] status
);
   import pmsp_pkg::*;

   // input register
   logic            in_valid_ff, in_valid_in;
   pmsp_item_type   in_item_ff, in_item_in;

   // parse state
   pmsp_state_type  state_ff, state_in;

   // result register
   logic            out_valid_ff, out_valid_in;
   pmsp_result_type out_result_ff, out_result_in;

   pmsp_result_type step_result;
   logic            in_fire;
   logic            req_fire;
   logic            rsp_fire;
   logic            is_end;

   assign is_end   = (in_item_ff.kind == KIND_END);
   assign rsp_fire = out_valid_ff && rsp_tready;

   // held item moves on unless it is an end with the result slot still busy
   assign in_fire    = in_valid_ff && (!is_end || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || in_fire;
   assign req_fire   = req_tvalid && req_tready;

   pmsp_step u_step (
      .state_cur (state_ff),
      .item      (in_item_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      if (req_fire) begin
         in_item_in.kind         = req_tuser;
         in_item_in.current_mode = req_tdata[11:0];
         in_item_in.char_code    = req_tdata[19:12];
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_fire;
      out_result_in = out_result_ff;
      if (in_fire && is_end) begin
         out_valid_in  = 1'b1;
         out_result_in = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_item_ff    <= in_item_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_result_ff.result_mode};
   assign rsp_tuser  = out_result_ff.status;

   // an end transaction that moves on always leaves a result behind
   `PMSP_ASSERT_NEXT(a_end_gives_result, clock, reset,
      in_fire && is_end, out_valid_ff, "end transaction produced no result")

   // invalid strings always report zero mode with invalid status
   `PMSP_ASSERT_NEXT(a_invalid_result, clock, reset,
      in_fire && is_end && state_ff.invalid_flag,
      out_result_ff.status == ST_INVALID && out_result_ff.result_mode == 12'd0,
      "invalid string gave wrong result")

   // overflow can only build up while reading an octal number
   `PMSP_ASSERT_SAME(a_overflow_octal, clock, reset,
      state_ff.overflow_flag && !state_ff.invalid_flag, state_ff.phase == PH_OCTAL,
      "overflow flag outside octal phase")

   // non-end transactions never touch the result register
   `PMSP_ASSERT_NEXT(a_char_no_result, clock, reset,
      in_fire && !is_end && !out_valid_ff, !out_valid_ff,
      "result produced by a non-end transaction")

endmodule
